/* hw/rtl/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants for the box point sampler
// Field widths, face codes, register indexes and the small helpers used by
// the face selection and placement pipelines.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int CoordW = 16;  // signed Q8.8 coordinate
  localparam int FracW  = 16;  // unsigned Q0.16 fraction
  localparam int DiffW  = CoordW + 1;
  localparam int AreaW  = 2 * CoordW;
  localparam int CumW   = AreaW + 3;  // six face areas summed
  localparam int LhsW   = CumW + FracW;
  localparam int NumFaces = 6;

  // Face codes on the output
  typedef enum logic [2:0] {
    FACE_MIN_Z  = 3'd0,
    FACE_MAX_Z  = 3'd1,
    FACE_MIN_Y  = 3'd2,
    FACE_MAX_Y  = 3'd3,
    FACE_MIN_X  = 3'd4,
    FACE_MAX_X  = 3'd5,
    FACE_VOLUME = 3'd6
  } face_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MIN_X        = 3'd0,
    REG_MIN_Y        = 3'd1,
    REG_MIN_Z        = 3'd2,
    REG_MAX_X        = 3'd3,
    REG_MAX_Y        = 3'd4,
    REG_MAX_Z        = 3'd5,
    REG_SURFACE_MODE = 3'd6
  } cfg_reg_e;

  // Register file contents plus the signed side lengths
  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic                     surface_mode;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic signed [DiffW-1:0]  dz;
  } cfg_t;

  typedef struct packed {
    logic [FracW-1:0] rand_a;
    logic [FracW-1:0] rand_b;
    logic [FracW-1:0] rand_c;
  } rands_t;

  // Beat handed from face selection to placement
  typedef struct packed {
    face_e  face;
    rands_t rnd;
  } item_t;

  // Length as sign and magnitude
  typedef struct packed {
    logic              neg;
    logic [CoordW-1:0] mag;
  } len_t;

  // Negative side counts as zero
  function automatic logic [CoordW-1:0] clamp_len(logic signed [DiffW-1:0] d);
    return d[DiffW-1] ? '0 : d[CoordW-1:0];
  endfunction

  // Surface mode clamps, volume mode keeps the sign
  function automatic len_t lane_len(logic signed [DiffW-1:0] d, logic surf);
    len_t l;
    logic signed [DiffW-1:0] nd;
    nd = -d;
    l.neg = 1'b0;
    l.mag = d[CoordW-1:0];
    if (d[DiffW-1]) begin
      if (surf) begin
        l.mag = '0;
      end else begin
        l.neg = 1'b1;
        l.mag = nd[CoordW-1:0];
      end
    end
    return l;
  endfunction

endpackage

/* hw/rtl/bps_cfg.sv */
// ----------------------------------------------------------------------------
// bps_cfg: configuration registers
// Holds the box corners and the mode, and derives the signed side lengths.
// ----------------------------------------------------------------------------
module bps_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [bps_pkg::CoordW-1:0] cfg_wdata_i,
  output bps_pkg::cfg_t             cfg_o
);

  logic signed [bps_pkg::CoordW-1:0] min_x_q, min_y_q, min_z_q;
  logic signed [bps_pkg::CoordW-1:0] max_x_q, max_y_q, max_z_q;
  logic                              surface_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q   <= '0;
      min_y_q   <= '0;
      min_z_q   <= '0;
      max_x_q   <= bps_pkg::CoordW'(256);
      max_y_q   <= bps_pkg::CoordW'(256);
      max_z_q   <= bps_pkg::CoordW'(256);
      surface_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bps_pkg::REG_MIN_X:        min_x_q   <= cfg_wdata_i;
        bps_pkg::REG_MIN_Y:        min_y_q   <= cfg_wdata_i;
        bps_pkg::REG_MIN_Z:        min_z_q   <= cfg_wdata_i;
        bps_pkg::REG_MAX_X:        max_x_q   <= cfg_wdata_i;
        bps_pkg::REG_MAX_Y:        max_y_q   <= cfg_wdata_i;
        bps_pkg::REG_MAX_Z:        max_z_q   <= cfg_wdata_i;
        bps_pkg::REG_SURFACE_MODE: surface_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Side lengths, one bit wider so they cannot wrap
  always_comb begin
    cfg_o.min_x        = min_x_q;
    cfg_o.min_y        = min_y_q;
    cfg_o.min_z        = min_z_q;
    cfg_o.max_x        = max_x_q;
    cfg_o.max_y        = max_y_q;
    cfg_o.max_z        = max_z_q;
    cfg_o.surface_mode = surface_q;
    cfg_o.dx = bps_pkg::DiffW'(max_x_q) - bps_pkg::DiffW'(min_x_q);
    cfg_o.dy = bps_pkg::DiffW'(max_y_q) - bps_pkg::DiffW'(min_y_q);
    cfg_o.dz = bps_pkg::DiffW'(max_z_q) - bps_pkg::DiffW'(min_z_q);
  end

endmodule

/* hw/rtl/bps_face.sv */
// ----------------------------------------------------------------------------
// bps_face: face selection pipeline
// Five stages: input capture, face areas, cumulative areas, pick times total,
// interval search. Volume mode tags the beat as a volume sample.
// ----------------------------------------------------------------------------
module bps_face (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bps_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [bps_pkg::FracW-1:0]  pick_i,
  input  bps_pkg::rands_t            rnd_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bps_pkg::item_t             item_o
);

  localparam int CumW = bps_pkg::CumW;

  // Stage valids and load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o  = rdy1;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Stage 1: capture
  logic [bps_pkg::FracW-1:0] pick1_q, pick2_q, pick3_q;
  bps_pkg::rands_t           rnd1_q, rnd2_q, rnd3_q, rnd4_q;

  // Stage 1 -> 2: face areas from clamped sides
  logic [bps_pkg::CoordW-1:0] dx_c, dy_c, dz_c;
  logic [bps_pkg::AreaW-1:0]  axy_d, axz_d, azy_d;
  logic [bps_pkg::AreaW-1:0]  axy_q, axz_q, azy_q;

  always_comb begin
    dx_c  = bps_pkg::clamp_len(cfg_i.dx);
    dy_c  = bps_pkg::clamp_len(cfg_i.dy);
    dz_c  = bps_pkg::clamp_len(cfg_i.dz);
    axy_d = bps_pkg::AreaW'(dx_c) * bps_pkg::AreaW'(dy_c);
    axz_d = bps_pkg::AreaW'(dx_c) * bps_pkg::AreaW'(dz_c);
    azy_d = bps_pkg::AreaW'(dz_c) * bps_pkg::AreaW'(dy_c);
  end

  // Stage 2 -> 3: cumulative face areas
  logic [CumW-1:0] cum_d [bps_pkg::NumFaces];
  logic [CumW-1:0] cum3_q [bps_pkg::NumFaces];
  logic [CumW-1:0] cum4_q [bps_pkg::NumFaces];
  logic [CumW-1:0] s_xy, s_xyz, s_all;

  always_comb begin
    s_xy     = CumW'(axy_q) + CumW'(axz_q);
    s_all    = s_xy + CumW'(azy_q);
    s_xyz    = s_xy << 1;
    cum_d[0] = CumW'(axy_q);
    cum_d[1] = CumW'(axy_q) << 1;
    cum_d[2] = (CumW'(axy_q) << 1) + CumW'(axz_q);
    cum_d[3] = s_xyz;
    cum_d[4] = s_xyz + CumW'(azy_q);
    cum_d[5] = s_all << 1;
  end

  // Stage 3 -> 4: pick fraction times total area
  logic [bps_pkg::LhsW-1:0] lhs_d, lhs4_q;

  assign lhs_d = bps_pkg::LhsW'(pick3_q) * bps_pkg::LhsW'(cum3_q[bps_pkg::NumFaces-1]);

  // Stage 4 -> 5: lowest interval that holds the scaled pick
  bps_pkg::face_e face_d;
  bps_pkg::item_t item5_q;

  always_comb begin
    face_d = bps_pkg::FACE_MIN_Z;
    for (int k = bps_pkg::NumFaces - 1; k >= 0; k--) begin
      if (lhs4_q < {cum4_q[k], {bps_pkg::FracW{1'b0}}}) begin
        face_d = bps_pkg::face_e'(3'(k));
      end
    end
    if (!cfg_i.surface_mode) begin
      face_d = bps_pkg::FACE_VOLUME;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pick1_q <= pick_i;
      rnd1_q  <= rnd_i;
    end
    if (rdy2) begin
      pick2_q <= pick1_q;
      rnd2_q  <= rnd1_q;
      axy_q   <= axy_d;
      axz_q   <= axz_d;
      azy_q   <= azy_d;
    end
    if (rdy3) begin
      pick3_q <= pick2_q;
      rnd3_q  <= rnd2_q;
      cum3_q  <= cum_d;
    end
    if (rdy4) begin
      rnd4_q <= rnd3_q;
      lhs4_q <= lhs_d;
      cum4_q <= cum3_q;
    end
    if (rdy5) begin
      item5_q.face <= face_d;
      item5_q.rnd  <= rnd4_q;
    end
  end

  assign item_o = item5_q;

endmodule

/* hw/rtl/bps_place.sv */
// ----------------------------------------------------------------------------
// bps_place: point placement pipeline
// Two stages: per-axis fraction times side length, then offset from the min
// corner or the fixed face coordinate. The last stage is the output register.
// ----------------------------------------------------------------------------
module bps_place (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bps_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bps_pkg::item_t              item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bps_pkg::CoordW-1:0]  point_x_o,
  output logic [bps_pkg::CoordW-1:0]  point_y_o,
  output logic [bps_pkg::CoordW-1:0]  point_z_o,
  output bps_pkg::face_e              face_o
);

  localparam int CoordW = bps_pkg::CoordW;
  localparam int ProdW  = bps_pkg::FracW + CoordW;

  logic v1_q, v2_q;
  logic rdy1, rdy2;

  assign rdy2 = !v2_q || out_ready_i;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o  = rdy1;
  assign out_valid_o = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // Stage 1: pick fraction and length per axis, multiply
  logic                       surf, on_x_face;
  logic [bps_pkg::FracW-1:0]  rx, ry, rz;
  bps_pkg::len_t              lx, ly, lz;
  logic [ProdW-1:0]           px, py, pz;

  always_comb begin
    surf      = item_i.face != bps_pkg::FACE_VOLUME;
    on_x_face = (item_i.face == bps_pkg::FACE_MIN_X) ||
                (item_i.face == bps_pkg::FACE_MAX_X);
    lx = bps_pkg::lane_len(cfg_i.dx, surf);
    ly = bps_pkg::lane_len(cfg_i.dy, surf);
    lz = bps_pkg::lane_len(cfg_i.dz, surf);
    rx = item_i.rnd.rand_a;
    ry = on_x_face ? item_i.rnd.rand_a : item_i.rnd.rand_b;
    rz = surf ? item_i.rnd.rand_b : item_i.rnd.rand_c;
    px = ProdW'(rx) * ProdW'(lx.mag);
    py = ProdW'(ry) * ProdW'(ly.mag);
    pz = ProdW'(rz) * ProdW'(lz.mag);
  end

  logic [CoordW-1:0] qx_q, qy_q, qz_q;
  logic              nx_q, ny_q, nz_q;
  bps_pkg::face_e    face1_q;

  // Stage 2: signed offset added to min, or fixed face coordinate
  logic [CoordW-1:0] ox, oy, oz;
  logic [CoordW-1:0] x_d, y_d, z_d;

  always_comb begin
    ox  = nx_q ? (~qx_q + CoordW'(1)) : qx_q;
    oy  = ny_q ? (~qy_q + CoordW'(1)) : qy_q;
    oz  = nz_q ? (~qz_q + CoordW'(1)) : qz_q;
    x_d = cfg_i.min_x + ox;
    y_d = cfg_i.min_y + oy;
    z_d = cfg_i.min_z + oz;
    case (face1_q)
      bps_pkg::FACE_MIN_Z: z_d = cfg_i.min_z;
      bps_pkg::FACE_MAX_Z: z_d = cfg_i.max_z;
      bps_pkg::FACE_MIN_Y: y_d = cfg_i.min_y;
      bps_pkg::FACE_MAX_Y: y_d = cfg_i.max_y;
      bps_pkg::FACE_MIN_X: x_d = cfg_i.min_x;
      bps_pkg::FACE_MAX_X: x_d = cfg_i.max_x;
      default: ;
    endcase
  end

  logic [CoordW-1:0] x_q, y_q, z_q;
  bps_pkg::face_e    face2_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      qx_q    <= px[ProdW-1:bps_pkg::FracW];
      qy_q    <= py[ProdW-1:bps_pkg::FracW];
      qz_q    <= pz[ProdW-1:bps_pkg::FracW];
      nx_q    <= lx.neg;
      ny_q    <= ly.neg;
      nz_q    <= lz.neg;
      face1_q <= item_i.face;
    end
    if (rdy2) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      face2_q <= face1_q;
    end
  end

  assign point_x_o = x_q;
  assign point_y_o = y_q;
  assign point_z_o = z_q;
  assign face_o    = face2_q;

endmodule

/* hw/rtl/box_point_sampler.sv */
// ----------------------------------------------------------------------------
// box_point_sampler: uniform random point in an axis-aligned box
// Volume or area-weighted surface sampling of a box given by two corners.
//
//   channel  dir  fields (low bit first)
//   s_axis   in   tdata: pick_fraction, rand_a, rand_b, rand_c
//   m_axis   out  tdata: point_x, point_y, point_z, face_used, zero fill
//   cfg      in   cfg_we_i / cfg_idx_i / cfg_wdata_i, write only
//
// One beat per cycle while the output is not stalled; the path from input beat
// to output beat runs through five face selection stages and two placement stages.
// Every stage has its own valid bit and loads when empty or when the stage
// after it moves, so bubbles close up under an output stall.
// Reset clears all valid bits and loads the default unit box in volume mode.
// ----------------------------------------------------------------------------
module box_point_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // pick_fraction, rand_a, rand_b, rand_c
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // point_x, point_y, point_z, face_used, pad
);

  bps_pkg::cfg_t   cfg;
  bps_pkg::rands_t rnd;
  bps_pkg::item_t  item;
  bps_pkg::face_e  face;
  logic            item_valid, item_ready;
  logic [15:0]     px, py, pz;

  bps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Unpack input beat
  always_comb begin
    rnd.rand_a = s_axis_tdata[31:16];
    rnd.rand_b = s_axis_tdata[47:32];
    rnd.rand_c = s_axis_tdata[63:48];
  end

  bps_face u_face (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pick_i      (s_axis_tdata[15:0]),
    .rnd_i       (rnd),
    .out_valid_o (item_valid),
    .out_ready_i (item_ready),
    .item_o      (item)
  );

  bps_place u_place (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (item_valid),
    .in_ready_o  (item_ready),
    .item_i      (item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .point_x_o   (px),
    .point_y_o   (py),
    .point_z_o   (pz),
    .face_o      (face)
  );

  // Pack output beat
  assign m_axis_tdata = {5'b0, face, pz, py, px};

endmodule

/* hw/rtl/bps_checker.sv */
// ----------------------------------------------------------------------------
// bps_checker: port-level checks for the box point sampler
// Watches the two stream channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
module bps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // Output beat held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");

  // Input side only backs up when the output is full and stalled
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output can move");

  // Face code stays within the defined codes
  a_face_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[50:48] != 3'd7)
    else $error("undefined face code");

  // Fill bits are zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:51] == 5'b0)
    else $error("nonzero fill bits");

  // Empty pipeline accepts immediately after reset
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready && !m_axis_tvalid)
    else $error("not ready after reset");

endmodule

bind box_point_sampler bps_checker u_bps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/box_point_sampler_test.sv */
// ----------------------------------------------------------------------------
// box_point_sampler_test: self-checking bench for the box point sampler
// Programs box corners and the sampling mode through the write port, streams
// random fractions in, and compares every output point and face code against
// a behavioral predictor kept in this bench. Both stream sides stall at
// random, with one long stretch of full rate.
// ----------------------------------------------------------------------------
module box_point_sampler_test;

  localparam logic [2:0] REG_SPARE = 3'd7;  // unmapped index, write is dropped
  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bps_pkg::face_e     face;
  } box_point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // pick_fraction, rand_a, rand_b, rand_c
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // point_x, point_y, point_z, face_used, pad

  // bench copy of the register file
  int   corner_lo [3] = '{0, 0, 0};
  int   corner_hi [3] = '{256, 256, 256};
  logic surface_on = 1'b0;

  box_point_t expected_points [$];
  box_point_t want;
  int         errors = 0;
  logic       steady_flow = 1'b0;

  box_point_sampler DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // fraction times length, truncated toward zero
  function automatic longint scaled_len(logic [15:0] r, longint d);
    longint q;
    q = (longint'(r) * (d < 0 ? -d : d)) >>> 16;
    return d < 0 ? -q : q;
  endfunction

  // expected point for one beat under the current register copy
  function automatic box_point_t sample_point(logic [15:0] pick, ra, rb, rc);
    box_point_t p;
    longint d [3];
    longint cum [6];
    longint lhs;
    int face_idx;
    if (!surface_on) begin
      p.x = 16'(corner_lo[AX_X] +
                scaled_len(ra, longint'(corner_hi[AX_X] - corner_lo[AX_X])));
      p.y = 16'(corner_lo[AX_Y] +
                scaled_len(rb, longint'(corner_hi[AX_Y] - corner_lo[AX_Y])));
      p.z = 16'(corner_lo[AX_Z] +
                scaled_len(rc, longint'(corner_hi[AX_Z] - corner_lo[AX_Z])));
      p.face = bps_pkg::FACE_VOLUME;
      return p;
    end
    // inverted sides count as zero length
    for (int a = 0; a < 3; a++) begin
      d[a] = longint'(corner_hi[a] - corner_lo[a]);
      if (d[a] < 0) d[a] = 0;
    end
    cum[0] = d[AX_X] * d[AX_Y];
    cum[1] = cum[0] + d[AX_X] * d[AX_Y];
    cum[2] = cum[1] + d[AX_X] * d[AX_Z];
    cum[3] = cum[2] + d[AX_X] * d[AX_Z];
    cum[4] = cum[3] + d[AX_Z] * d[AX_Y];
    cum[5] = cum[4] + d[AX_Z] * d[AX_Y];
    // first face whose cumulative area exceeds pick * total
    face_idx = 0;
    if (cum[5] != 0) begin
      lhs = longint'(pick) * cum[5];
      for (int k = 5; k >= 0; k--) begin
        if (lhs < (cum[k] << 16)) face_idx = k;
      end
    end
    p.face = bps_pkg::face_e'(face_idx);
    case (p.face)
      bps_pkg::FACE_MIN_Z, bps_pkg::FACE_MAX_Z: begin
        p.x = 16'(corner_lo[AX_X] + scaled_len(ra, d[AX_X]));
        p.y = 16'(corner_lo[AX_Y] + scaled_len(rb, d[AX_Y]));
        p.z = (p.face == bps_pkg::FACE_MIN_Z) ? 16'(corner_lo[AX_Z])
                                              : 16'(corner_hi[AX_Z]);
      end
      bps_pkg::FACE_MIN_Y, bps_pkg::FACE_MAX_Y: begin
        p.x = 16'(corner_lo[AX_X] + scaled_len(ra, d[AX_X]));
        p.y = (p.face == bps_pkg::FACE_MIN_Y) ? 16'(corner_lo[AX_Y])
                                              : 16'(corner_hi[AX_Y]);
        p.z = 16'(corner_lo[AX_Z] + scaled_len(rb, d[AX_Z]));
      end
      default: begin
        p.x = (p.face == bps_pkg::FACE_MIN_X) ? 16'(corner_lo[AX_X])
                                              : 16'(corner_hi[AX_X]);
        p.y = 16'(corner_lo[AX_Y] + scaled_len(ra, d[AX_Y]));
        p.z = 16'(corner_lo[AX_Z] + scaled_len(rb, d[AX_Z]));
      end
    endcase
    return p;
  endfunction

  // one register write; caller closes a burst with end_writes
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      bps_pkg::REG_MIN_X: corner_lo[AX_X] = int'($signed(value));
      bps_pkg::REG_MIN_Y: corner_lo[AX_Y] = int'($signed(value));
      bps_pkg::REG_MIN_Z: corner_lo[AX_Z] = int'($signed(value));
      bps_pkg::REG_MAX_X: corner_hi[AX_X] = int'($signed(value));
      bps_pkg::REG_MAX_Y: corner_hi[AX_Y] = int'($signed(value));
      bps_pkg::REG_MAX_Z: corner_hi[AX_Z] = int'($signed(value));
      bps_pkg::REG_SURFACE_MODE: surface_on = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and wait for every outstanding point
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_points.size() != 0);
  endtask

  task automatic program_box(input logic [15:0] lx, ly, lz, hx, hy, hz, mode);
    drain_results();
    write_reg(bps_pkg::REG_MIN_X, lx);
    write_reg(bps_pkg::REG_MIN_Y, ly);
    write_reg(bps_pkg::REG_MIN_Z, lz);
    write_reg(bps_pkg::REG_MAX_X, hx);
    write_reg(bps_pkg::REG_MAX_Y, hy);
    write_reg(bps_pkg::REG_MAX_Z, hz);
    write_reg(bps_pkg::REG_SURFACE_MODE, mode);
    end_writes();
  endtask

  // one input beat, with a random gap ahead of it
  task automatic send_sample(input logic [15:0] pick, ra, rb, rc);
    while (!steady_flow && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rc, rb, ra, pick};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_points = {expected_points, sample_point(pick, ra, rb, rc)};
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v, got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // output stalls
  always @(posedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(99) >= 24);
  end

  // output checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected output beat %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_points.pop_front();
        check_field("point_x", want.x, m_axis_tdata[15:0]);
        check_field("point_y", want.y, m_axis_tdata[31:16]);
        check_field("point_z", want.z, m_axis_tdata[47:32]);
        check_field("face_used", {13'd0, want.face}, {13'd0, m_axis_tdata[50:48]});
      end
    end
  end

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_corner();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(4095)) - 16'd2048;
    endcase
  endfunction

  // reset box, volume mode, fraction extremes
  task automatic test_default_box();
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h1234, 16'h8000, 16'h4000, 16'h0001);
  endtask

  // widest box and fully inverted box in volume mode
  task automatic test_volume_extremes();
    program_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000);
    send_sample(16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF);
    program_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_sample(16'hAAAA, 16'hFFFF, 16'h8000, 16'h5555);
    send_sample(16'h5555, 16'h0001, 16'h0000, 16'hFFFF);
  endtask

  // cube of side two centered at zero: equal faces, picks on each face boundary
  task automatic test_surface_faces();
    logic [15:0] picks [8] = '{16'd0, 16'd10922, 16'd10923, 16'd21846,
                               16'd32769, 16'd43692, 16'd54615, 16'hFFFF};
    // extra bits above the mode bit are ignored
    program_box(16'hFF00, 16'hFF00, 16'hFF00, 16'h0100, 16'h0100, 16'h0100, 16'h0003);
    foreach (picks[i]) send_sample(picks[i], (i % 2) ? 16'hFFFF : 16'h0000,
                                   16'($urandom), 16'($urandom));
  endtask

  // zero area, inverted and flat boxes, mode bit masking, unmapped index
  task automatic test_degenerate_boxes();
    program_box(16'h0280, 16'hFE00, 16'h0040, 16'h0280, 16'hFE00, 16'h0040, 16'h0001);
    send_sample(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    program_box(16'h0300, 16'h0200, 16'h0100, 16'hFD00, 16'hFE00, 16'hFF00, 16'h0001);
    send_sample(16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
    program_box(16'hF000, 16'h0000, 16'h0500, 16'h1000, 16'h0800, 16'h0500, 16'h0001);
    send_sample(16'hFFFF, 16'h4321, 16'hFEDC, 16'h0000);
    drain_results();
    write_reg(bps_pkg::REG_SURFACE_MODE, 16'hFFFE);
    write_reg(REG_SPARE, 16'($urandom));
    end_writes();
    send_sample(16'hFFFF, 16'h4321, 16'hFEDC, 16'hFFFF);
  endtask

  // random boxes and modes, one phase per setting
  task automatic test_random_boxes();
    logic [15:0] lo [3];
    logic [15:0] hi [3];
    logic [15:0] tmp;
    for (int phase = 0; phase < 14; phase++) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = rand_corner();
        hi[a] = rand_corner();
        if ($urandom_range(4) != 0 && $signed(lo[a]) > $signed(hi[a])) begin
          tmp = lo[a];
          lo[a] = hi[a];
          hi[a] = tmp;
        end
      end
      program_box(lo[AX_X], lo[AX_Y], lo[AX_Z], hi[AX_X], hi[AX_Y], hi[AX_Z],
                  {15'($urandom), phase[0]});
      // phases five and six run without stalls
      steady_flow <= (phase == 5 || phase == 6);
      for (int n = 0; n < 130; n++) begin
        send_sample(rand_frac(), rand_frac(), rand_frac(), rand_frac());
      end
    end
    steady_flow <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_box();
    test_volume_extremes();
    test_surface_faces();
    test_degenerate_boxes();
    test_random_boxes();
    drain_results();
    repeat (16) @(posedge clk_i);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("box_point_sampler_test passed");
    end else begin
      $display("box_point_sampler_test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("box_point_sampler_test failed");
    $finish;
  end

endmodule
